@@ hw/rtl/miq_pkg.sv @@
// ----------------------------------------------------------------------------
// miq_pkg
// Command and status codes shared by the middle insert queue and its checker.
// ----------------------------------------------------------------------------
`default_nettype none

package miq_pkg;

  localparam int KIND_W   = 2;
  localparam int STATUS_W = 2;
  localparam int OUT_W    = 32;

  localparam logic [KIND_W-1:0] KIND_PUSH   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_INSERT = 2'd1;
  localparam logic [KIND_W-1:0] KIND_POP    = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

endpackage

`default_nettype wire

@@ hw/rtl/middle_insert_queue_unit.sv @@
// ----------------------------------------------------------------------------
// middle_insert_queue_unit
// FIFO queue with insertion at its middle, kept as two ring memories. The
// front ring holds the first half (rounded up), the back ring the rest.
// ----------------------------------------------------------------------------
//  channel   | ports                                   | handshake
//  ----------+-----------------------------------------+------------------------
//  command   | start, kind, value                      | beat when start && !busy
//  result    | done, popped_value, has_value, status   | one-cycle strobe on done
//
// On acceptance both ring heads are read from the synchronous memories; in
// S_EXEC the block then writes back, updates the pointers and registers the
// result. A new command may be accepted while that result is shown, but not
// while busy. Reset clears the state, done, pointers and counts only; the
// memories need no clearing pass. The receiver cannot stall, so done lasts
// one cycle.
`default_nettype none

module middle_insert_queue_unit
  import miq_pkg::*;
#(
  parameter int CAPACITY   = 1024,
  parameter int VALUE_BITS = 32
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 start,
  input  wire logic [KIND_W-1:0]    kind,
  input  wire logic signed [31:0]   value,
  output logic                      busy,
  output logic                      done,
  output logic signed [31:0]        popped_value,
  output logic                      has_value,
  output logic [STATUS_W-1:0]       status
);

  localparam int RD    = (CAPACITY + 1) / 2;
  localparam int PTR_W = (RD > 1) ? $clog2(RD) : 1;
  localparam int CNT_W = $clog2(RD + 1);
  localparam int TOT_W = $clog2(CAPACITY + 1);

  typedef enum logic {S_IDLE, S_EXEC} state_t;

  state_t state;

  logic [VALUE_BITS-1:0] front_mem [RD];
  logic [VALUE_BITS-1:0] back_mem  [RD];

  logic [PTR_W-1:0] front_head, back_head;
  logic [CNT_W-1:0] front_count, back_count;
  logic [TOT_W-1:0] total_count;

  logic [KIND_W-1:0]     cmd_kind;
  logic [VALUE_BITS-1:0] cmd_val;
  logic [VALUE_BITS-1:0] front_rd, back_rd;
  logic [VALUE_BITS-1:0] value_st;
  logic [OUT_W-1:0]      front_out;

  logic accept;
  assign accept = start && (state == S_IDLE);
  assign busy   = (state == S_EXEC);

  // Stored width follows VALUE_BITS; input is sign-extended or truncated.
  generate
    if (VALUE_BITS <= 32) begin : g_in_narrow
      assign value_st = value[VALUE_BITS-1:0];
    end else begin : g_in_wide
      assign value_st = {{(VALUE_BITS-32){value[31]}}, value};
    end
    if (VALUE_BITS >= 32) begin : g_out_wide
      assign front_out = front_rd[31:0];
    end else begin : g_out_narrow
      assign front_out = {{(32-VALUE_BITS){front_rd[VALUE_BITS-1]}}, front_rd};
    end
  endgenerate

  // Ring position arithmetic.
  logic [CNT_W:0]   front_sum, back_sum;
  logic [PTR_W-1:0] front_tail, back_tail;
  logic [PTR_W-1:0] front_head_inc, back_head_inc, back_head_dec;

  always_comb begin
    front_sum = (CNT_W+1)'(front_head) + (CNT_W+1)'(front_count);
    back_sum  = (CNT_W+1)'(back_head) + (CNT_W+1)'(back_count);
    if (front_sum >= (CNT_W+1)'(RD)) begin
      front_tail = PTR_W'(front_sum - (CNT_W+1)'(RD));
    end else begin
      front_tail = PTR_W'(front_sum);
    end
    if (back_sum >= (CNT_W+1)'(RD)) begin
      back_tail = PTR_W'(back_sum - (CNT_W+1)'(RD));
    end else begin
      back_tail = PTR_W'(back_sum);
    end
    front_head_inc = (front_head == PTR_W'(RD - 1)) ? '0 : front_head + PTR_W'(1);
    back_head_inc  = (back_head == PTR_W'(RD - 1)) ? '0 : back_head + PTR_W'(1);
    back_head_dec  = (back_head == '0) ? PTR_W'(RD - 1) : back_head - PTR_W'(1);
  end

  // Write-back decision for the command held in S_EXEC.
  logic                  fw_en, bw_en;
  logic [PTR_W-1:0]      fw_addr, bw_addr;
  logic [VALUE_BITS-1:0] fw_data, bw_data;
  logic [PTR_W-1:0]      front_head_next, back_head_next;
  logic [CNT_W-1:0]      front_count_next, back_count_next;
  logic [TOT_W-1:0]      total_count_next;
  logic [OUT_W-1:0]      popped_next;
  logic                  has_next;
  logic [STATUS_W-1:0]   status_next;
  logic                  is_full, is_empty, front_room;

  always_comb begin
    is_full    = (total_count >= TOT_W'(CAPACITY)) || (back_count >= CNT_W'(RD));
    is_empty   = (total_count == '0) || (front_count == '0);
    front_room = (front_count < CNT_W'(RD));

    fw_en = 1'b0;
    bw_en = 1'b0;
    fw_addr = front_tail;
    bw_addr = back_tail;
    fw_data = cmd_val;
    bw_data = cmd_val;
    front_head_next  = front_head;
    back_head_next   = back_head;
    front_count_next = front_count;
    back_count_next  = back_count;
    total_count_next = total_count;
    popped_next = '0;
    has_next    = 1'b0;
    status_next = ST_OK;

    unique case (cmd_kind)
      KIND_PUSH, KIND_INSERT: begin
        if (is_full) begin
          status_next = ST_FULL;
        end else begin
          total_count_next = total_count + TOT_W'(1);
          // An even count before the push means an odd count after it.
          if (!total_count[0] && front_room) begin
            fw_en = 1'b1;
            front_count_next = front_count + CNT_W'(1);
            if (cmd_kind == KIND_INSERT || back_count == '0) begin
              // The new entry would be the back head, so it moves straight on.
              fw_data = cmd_val;
            end else begin
              fw_data = back_rd;
              bw_en   = 1'b1;
              back_head_next = back_head_inc;
            end
          end else begin
            bw_en = 1'b1;
            back_count_next = back_count + CNT_W'(1);
            if (cmd_kind == KIND_INSERT) begin
              bw_addr = back_head_dec;
              back_head_next = back_head_dec;
            end
          end
        end
      end
      KIND_POP: begin
        if (is_empty) begin
          status_next = ST_EMPTY;
        end else begin
          popped_next = front_out;
          has_next    = 1'b1;
          front_head_next  = front_head_inc;
          total_count_next = total_count - TOT_W'(1);
          // After the pop the front tail lands on the old tail position.
          if (!total_count[0] && back_count != '0) begin
            fw_en   = 1'b1;
            fw_data = back_rd;
            back_head_next  = back_head_inc;
            back_count_next = back_count - CNT_W'(1);
          end else begin
            front_count_next = front_count - CNT_W'(1);
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      front_rd <= front_mem[front_head];
    end
    if (busy && fw_en) begin
      front_mem[fw_addr] <= fw_data;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      back_rd <= back_mem[back_head];
    end
    if (busy && bw_en) begin
      back_mem[bw_addr] <= bw_data;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_kind <= kind;
      cmd_val  <= value_st;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      done        <= 1'b0;
      front_head  <= '0;
      back_head   <= '0;
      front_count <= '0;
      back_count  <= '0;
      total_count <= '0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          state        <= S_IDLE;
          done         <= 1'b1;
          popped_value <= popped_next;
          has_value    <= has_next;
          status       <= status_next;
          front_head   <= front_head_next;
          back_head    <= back_head_next;
          front_count  <= front_count_next;
          back_count   <= back_count_next;
          total_count  <= total_count_next;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/miq_checker.sv @@
// ----------------------------------------------------------------------------
// miq_checker
// Port-level checks on command and result timing of the middle insert queue.
// ----------------------------------------------------------------------------
`default_nettype none

module miq_checker
  import miq_pkg::*;
(
  input wire logic                clk,
  input wire logic                rst,
  input wire logic                start,
  input wire logic                busy,
  input wire logic                done,
  input wire logic signed [31:0]  popped_value,
  input wire logic                has_value,
  input wire logic [STATUS_W-1:0] status
);

  // Every accepted beat is followed by busy and then by a result.
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy ##1 done)
    else $error("result did not follow an accepted command");

  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("result strobe without a command in flight");

  a_value_ok: assert property (@(posedge clk) disable iff (rst)
    (done && has_value) |-> (status == ST_OK))
    else $error("popped value carries a refusal status");

  a_zero_no_value: assert property (@(posedge clk) disable iff (rst)
    (done && !has_value) |-> (popped_value == 32'sd0))
    else $error("nonzero popped value without an entry");

endmodule

bind middle_insert_queue_unit miq_checker u_miq_checker (
  .clk          (clk),
  .rst          (rst),
  .start        (start),
  .busy         (busy),
  .done         (done),
  .popped_value (popped_value),
  .has_value    (has_value),
  .status       (status)
);

`default_nettype wire

@@ tb/sv/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for middle_insert_queue_unit. Commands are driven one
// beat at a time, and a scoreboard keeps its own copy of the two half-queue
// rings to work out each result. Every done strobe is compared field by field
// with the oldest expected result. The run starts with a short directed set,
// then goes through random phases with different sender gaps. The last phase
// fills the queue to capacity and then drains it partway.
// ----------------------------------------------------------------------------
module testbench;
  import miq_pkg::*;

  localparam int QUEUE_CAPACITY = 1024;
  localparam int RING_SLOTS     = (QUEUE_CAPACITY + 1) / 2;

  // The package leaves code 3 unnamed; the block ignores it.
  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

  typedef struct packed {
    logic signed [31:0]   popped;
    logic                 has;
    logic [STATUS_W-1:0]  status;
  } queue_result_t;

  class queue_book;
    logic [31:0]   front_ring [RING_SLOTS];
    logic [31:0]   back_ring [RING_SLOTS];
    logic [8:0]    front_head;
    logic [8:0]    back_head;
    logic [9:0]    front_count;
    logic [9:0]    back_count;
    logic [10:0]   total_count;
    queue_result_t awaited[$];
    int            errors;

    function new();
      front_head  = '0;
      back_head   = '0;
      front_count = '0;
      back_count  = '0;
      total_count = '0;
      errors      = 0;
    endfunction

    // An odd count means the front half is one short of ceil(n/2), so the
    // head of the back ring moves over to the tail of the front ring.
    function void rebalance();
      logic [8:0] slot;
      if (total_count[0] && back_count != 0 && front_count < RING_SLOTS) begin
        slot = front_head + front_count[8:0];
        front_ring[slot] = back_ring[back_head];
        back_head   = back_head + 9'd1;
        back_count  = back_count - 10'd1;
        front_count = front_count + 10'd1;
      end
    endfunction

    function void note_command(logic [KIND_W-1:0] k, logic [31:0] v);
      queue_result_t r;
      logic [8:0]    slot;
      r = '0;
      r.status = ST_OK;
      case (k)
        KIND_PUSH, KIND_INSERT: begin
          if (total_count >= QUEUE_CAPACITY || back_count >= RING_SLOTS) begin
            r.status = ST_FULL;
          end else begin
            if (k == KIND_PUSH) begin
              slot = back_head + back_count[8:0];
              back_ring[slot] = v;
            end else begin
              back_head = back_head - 9'd1;
              back_ring[back_head] = v;
            end
            back_count  = back_count + 10'd1;
            total_count = total_count + 11'd1;
            rebalance();
          end
        end
        KIND_POP: begin
          if (total_count == 0 || front_count == 0) begin
            r.status = ST_EMPTY;
          end else begin
            r.popped    = front_ring[front_head];
            r.has       = 1'b1;
            front_head  = front_head + 9'd1;
            front_count = front_count - 10'd1;
            total_count = total_count - 11'd1;
            rebalance();
          end
        end
        default: ;
      endcase
      awaited.insert(awaited.size(), r);
    endfunction

    task report(string msg);
      $display("[%0t] ERROR: %s", $realtime, msg);
      errors++;
    endtask

    task check_result(logic signed [31:0] popped, logic has, logic [STATUS_W-1:0] status);
      queue_result_t want;
      if (awaited.size() == 0) begin
        report($sformatf("result with nothing expected (value %h has %b status %0d)",
                         popped, has, status));
      end else begin
        want = awaited[0];
        awaited.delete(0);
        if (popped !== want.popped)
          report($sformatf("popped_value %h, expected %h", popped, want.popped));
        if (has !== want.has)
          report($sformatf("has_value %b, expected %b", has, want.has));
        if (status !== want.status)
          report($sformatf("status %0d, expected %0d", status, want.status));
      end
    endtask

    function int pending();
      return awaited.size();
    endfunction
  endclass

  logic                      clk;
  logic                      rst;
  logic                      start;
  logic [KIND_W-1:0]         kind;
  logic signed [31:0]        value;
  logic                      busy;
  logic                      done;
  logic signed [31:0]        popped_value;
  logic                      has_value;
  logic [STATUS_W-1:0]       status;

  queue_book book;

  middle_insert_queue_unit i_dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .kind         (kind),
    .value        (value),
    .busy         (busy),
    .done         (done),
    .popped_value (popped_value),
    .has_value    (has_value),
    .status       (status)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #1_000_000;
    $display("middle_insert_queue_unit: mismatch");
    $finish;
  end

  always @(posedge clk) begin
    if (!rst && done) begin
      book.check_result(popped_value, has_value, status);
    end
  end

  // One command beat. Start stays high afterwards unless the next call
  // decides to leave a gap.
  task automatic send_command(input logic [KIND_W-1:0] k, input logic [31:0] v,
                              input int idle_pct);
    @(negedge clk);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start <= 1'b1;
    kind  <= k;
    value <= v;
    do @(posedge clk); while (busy);
    book.note_command(k, v);
  endtask

  task automatic wait_drained();
    @(negedge clk);
    start <= 1'b0;
    while (book.pending() != 0) @(posedge clk);
  endtask

  function automatic logic [KIND_W-1:0] pick_kind(input int pop_pct);
    int roll;
    roll = $urandom_range(99);
    if (roll < 2) return KIND_UNUSED;
    if (roll < 2 + pop_pct) return KIND_POP;
    return $urandom_range(1) ? KIND_INSERT : KIND_PUSH;
  endfunction

  task automatic run_random(input int count, input int idle_pct, input int pop_pct);
    repeat (count) send_command(pick_kind(pop_pct), $urandom, idle_pct);
  endtask

  initial begin
    book  = new();
    rst   = 1'b1;
    start = 1'b0;
    kind  = KIND_PUSH;
    value = '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: empty pop, ignored code, value extremes, both insert forms.
    send_command(KIND_POP,    32'h0000_0000, 38);
    send_command(KIND_UNUSED, 32'hFFFF_FFFF, 38);
    send_command(KIND_PUSH,   32'h7FFF_FFFF, 38);
    send_command(KIND_PUSH,   32'h8000_0000, 38);
    send_command(KIND_INSERT, 32'h0000_0000, 38);
    send_command(KIND_INSERT, 32'hFFFF_FFFF, 38);
    send_command(KIND_PUSH,   32'h5555_5555, 38);
    send_command(KIND_UNUSED, 32'h1234_5678, 38);
    send_command(KIND_INSERT, 32'hAAAA_AAAA, 38);
    repeat (6) send_command(KIND_POP, 32'hFFFF_FFFF, 38);
    send_command(KIND_POP,    32'h0000_0000, 38);
    send_command(KIND_INSERT, 32'h0000_0001, 38);
    send_command(KIND_PUSH,   32'hFFFF_FFFE, 38);
    send_command(KIND_INSERT, 32'h8000_0001, 38);
    send_command(KIND_POP,    32'h0000_0000, 38);
    send_command(KIND_POP,    32'h0000_0000, 38);
    send_command(KIND_POP,    32'h0000_0000, 38);

    // Balanced mix keeps the queue shallow so empty pops keep turning up.
    run_random(70, 38, 48);
    wait_drained();
    run_random(50, 85, 30);
    wait_drained();

    // Back to back: fill to capacity, linger near full, then drain partway.
    while (book.total_count < QUEUE_CAPACITY) begin
      send_command(pick_kind(0), $urandom, 0);
    end
    run_random(30, 0, 35);
    run_random(40, 0, 60);

    wait_drained();
    repeat (8) @(posedge clk);
    if (book.errors == 0 && book.pending() == 0) begin
      $display("middle_insert_queue_unit: match");
    end else begin
      $display("middle_insert_queue_unit: mismatch");
    end
    $finish;
  end

endmodule
